// ===== rtl/thte_pkg.sv =====
// Package for the trigram hash text embedding block.
// Constants, hash helpers and shared types; no dependencies.
package thte_pkg;

	localparam int Dim = 32;
	localparam int DimW = (Dim > 1) ? $clog2(Dim) : 1;
	localparam int MaxText = 4096;
	localparam int CntW = $clog2(MaxText + 1);

	localparam logic [63:0] FnvOffset = 64'hCBF29CE484222325;
	localparam logic [63:0] FnvPrime = 64'h00000100000001B3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HASH,
		ST_PROJ,
		ST_MAX,
		ST_SHIFT,
		ST_SUMSQ,
		ST_SQRT,
		ST_DIV,
		ST_EMIT
	} state_t;

	// one cell-to-cell shift command for the accumulator row
	typedef struct packed {
		logic rotate;
		logic add;
		logic clear;
	} row_ctl_t;

	function automatic logic [63:0] xs_step(input logic [63:0] h);
		logic [63:0] a;
		logic [63:0] b;
		begin
			a = h ^ (h << 13);
			b = a ^ (a >> 7);
			xs_step = b ^ (b << 17);
		end
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] p);
		logic [32:0] s;
		begin
			s = {a[31], a} + {{17{p[15]}}, p};
			if (s[32] != s[31])
				sat_add = s[32] ? 32'h80000000 : 32'h7FFFFFFF;
			else
				sat_add = s[31:0];
		end
	endfunction

endpackage

// ===== rtl/thte_cell.sv =====
// One accumulator cell of the row.
// Depends on thte_pkg.
module thte_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  thte_pkg::row_ctl_t  ctl,
	input  logic [15:0]         proj,
	input  logic [31:0]         from_prev,
	output logic [31:0]         acc
);
	import thte_pkg::*;

	logic [31:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= sat_add(from_prev, proj);
		end else if (ctl.rotate) begin
			acc_q <= from_prev;
		end
	end

	assign acc = acc_q;
endmodule

// ===== rtl/thte_row.sv =====
// Ring of accumulator cells; the head is cell 0, and the projection is added in cell Dim-1.
// Depends on thte_pkg and thte_cell.
module thte_row (
	input  logic                clk,
	input  logic                arst_n,
	input  thte_pkg::row_ctl_t  ctl,
	input  logic [15:0]         proj,
	output logic [31:0]         head
);
	import thte_pkg::*;

	logic [31:0] acc [Dim];
	row_ctl_t    tail_ctl;

	always_comb begin
		tail_ctl = ctl;
		tail_ctl.add = 1'b0;
		tail_ctl.rotate = ctl.rotate | ctl.add;
	end

	// cell 0 feeds back into cell Dim-1; projection added as the value enters cell Dim-1
	genvar g;
	generate
		for (g = 0; g < Dim; g++) begin : g_cell
			if (g == Dim - 1) begin : g_last
				thte_cell u_cell (
					.clk(clk), .arst_n(arst_n), .ctl(ctl), .proj(proj),
					.from_prev(acc[0]), .acc(acc[g])
				);
			end else begin : g_mid
				thte_cell u_cell (
					.clk(clk), .arst_n(arst_n), .ctl(tail_ctl), .proj(proj),
					.from_prev(acc[g + 1]), .acc(acc[g])
				);
			end
		end
	endgenerate

	assign head = acc[0];
endmodule

// ===== rtl/trigram_hash_text_embedding_top.sv =====
// Top level of the trigram hash text embedding block.
// Depends on thte_pkg and thte_row.
//
// Bytes are taken one per transfer, and a byte is accepted only while the block is idle. Each
// hashed trigram takes the hash steps over its bytes, an xorshift step and a rotation of the
// accumulator ring through all Dim cells; a byte that emits a space and a character can add
// two such jobs, and at the end of a short text each character is hashed alone. At end of
// text the max, the scaling, the sum of squares and 32 square-root steps follow, then each of
// the Dim elements needs a restoring divide before its transfer, which waits on out_ready.
module trigram_hash_text_embedding_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] element_value,
	output logic [5:0]  element_index,
	output logic        last_element
);
	import thte_pkg::*;

	state_t         state_q, state_d;
	row_ctl_t       ctl;
	logic [31:0]    head;
	logic [63:0]    h_q;
	logic [1:0]     hstep_q;
	logic [DimW-1:0] d_q;
	logic [23:0]    hb_q;
	logic [1:0]     hn_q;
	logic [1:0]     jobs_q;
	logic [7:0]     job_c_q;
	logic [15:0]    win_q;
	logic [CntW-1:0] cnt_q;
	logic           pend_q;
	logic           eot_q;
	logic [31:0]    m_q;
	logic [4:0]     k_q;
	logic [63:0]    s_q;
	logic [63:0]    sx_q;
	logic [31:0]    r_q;
	logic [5:0]     sqi_q;
	logic [47:0]    num_q;
	logic [32:0]    rem_q;
	logic [5:0]     dvi_q;
	logic           neg_q;
	logic [15:0]    val_q;
	logic           ov_q;

	logic        alnum;
	logic [7:0]  lc;
	logic [31:0] mag;
	logic [25:0] v;
	logic [51:0] vsq;
	logic [63:0] h_nx;
	logic [33:0] sq_try;
	logic [33:0] sq_rem_sh;
	logic        few_chars;

	always_comb begin
		alnum = (char_byte >= 8'h30 && char_byte <= 8'h39) ||
		        (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
		        (char_byte >= 8'h61 && char_byte <= 8'h7A);
		lc = (char_byte >= 8'h41 && char_byte <= 8'h5A) ? char_byte + 8'd32 : char_byte;
		mag = head[31] ? 32'd0 - head : head;
		v = 26'(mag >> k_q);
		vsq = v * v;
		h_nx = xs_step(h_q);
		few_chars = (cnt_q == CntW'(1)) || (cnt_q == CntW'(2));
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign element_value = val_q;
	assign element_index = 6'(d_q);
	assign last_element = (d_q == DimW'(Dim - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sqrt: 2 bits of sx per step, restoring
	assign sq_rem_sh = {s_q[31:0], sx_q[63:62]};
	assign sq_try = sq_rem_sh - {r_q, 2'b01};

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_HASH;
			ST_HASH: if (jobs_q == 2'd0) begin
				if (!(eot_q && few_chars)) state_d = eot_q ? ST_MAX : ST_IDLE;
			end else if (hstep_q == hn_q) begin
				state_d = ST_PROJ;
			end
			ST_PROJ: begin
				ctl.add = 1'b1;
				if (d_q == DimW'(Dim - 1)) state_d = ST_HASH;
			end
			ST_MAX: begin
				ctl.rotate = 1'b1;
				if (d_q == DimW'(Dim - 1)) state_d = ST_SHIFT;
			end
			ST_SHIFT: if (m_q < 32'h04000000) state_d = ST_SUMSQ;
			ST_SUMSQ: begin
				ctl.rotate = 1'b1;
				if (d_q == DimW'(Dim - 1)) state_d = ST_SQRT;
			end
			ST_SQRT: if (sqi_q == 6'd31) state_d = ST_DIV;
			ST_DIV: if (dvi_q == 6'd49) state_d = ST_EMIT;
			ST_EMIT: if (out_ready) begin
				ctl.rotate = 1'b1;
				if (d_q == DimW'(Dim - 1)) begin
					ctl.clear = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DIV;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			cnt_q <= '0;
			pend_q <= 1'b0;
			eot_q <= 1'b0;
			jobs_q <= '0;
			hstep_q <= '0;
			d_q <= '0;
			ov_q <= 1'b0;
			k_q <= '0;
			m_q <= '0;
			s_q <= '0;
			sx_q <= '0;
			sqi_q <= '0;
			dvi_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					eot_q <= end_of_text;
					jobs_q <= '0;
					hstep_q <= '0;
					d_q <= '0;
					if (alnum) begin
						pend_q <= 1'b0;
						if (pend_q && cnt_q < CntW'(MaxText)) begin
							// space then char; both may form trigrams
							if (cnt_q + CntW'(1) < CntW'(MaxText)) begin
								win_q <= {8'h20, lc};
								cnt_q <= cnt_q + CntW'(2);
								hb_q <= (cnt_q == CntW'(1)) ? {win_q[7:0], 8'h20, lc} :
								        {win_q, 8'h20};
								job_c_q <= lc;
								jobs_q <= (cnt_q >= CntW'(2)) ? 2'd2 :
								          (cnt_q == CntW'(1)) ? 2'd1 : 2'd0;
								hn_q <= 2'd3;
							end else begin
								win_q <= {win_q[7:0], 8'h20};
								cnt_q <= cnt_q + CntW'(1);
								hb_q <= {win_q, 8'h20};
								hn_q <= 2'd3;
								jobs_q <= (cnt_q >= CntW'(2)) ? 2'd1 : 2'd0;
							end
						end else if (cnt_q < CntW'(MaxText)) begin
							win_q <= {win_q[7:0], lc};
							cnt_q <= cnt_q + CntW'(1);
							hb_q <= {win_q, lc};
							hn_q <= 2'd3;
							jobs_q <= (cnt_q >= CntW'(2)) ? 2'd1 : 2'd0;
						end
					end else if (cnt_q != '0) begin
						pend_q <= 1'b1;
					end
				end
				ST_HASH: begin
					if (jobs_q == 2'd0 && eot_q) begin
						// short text: each char hashed alone
						if (cnt_q == CntW'(1) || cnt_q == CntW'(2)) begin
							jobs_q <= (cnt_q == CntW'(2)) ? 2'd2 : 2'd1;
							hb_q <= {16'h0, (cnt_q == CntW'(2)) ? win_q[15:8] : win_q[7:0]};
							job_c_q <= win_q[7:0];
							hn_q <= 2'd1;
							hstep_q <= '0;
							eot_q <= 1'b1;
							cnt_q <= '0;
						end
					end
					if (jobs_q != 2'd0) begin
						if (hstep_q == 2'd0) begin
							h_q <= (FnvOffset ^ {56'h0, (hn_q == 2'd3) ? hb_q[23:16] : hb_q[7:0]})
							       * FnvPrime;
							hstep_q <= 2'd1;
						end else if (hstep_q != hn_q) begin
							h_q <= (h_q ^ {56'h0, (hstep_q == 2'd1) ? hb_q[15:8] : hb_q[7:0]})
							       * FnvPrime;
							hstep_q <= hstep_q + 2'd1;
						end else begin
							h_q <= h_nx;
							d_q <= '0;
						end
					end
				end
				ST_PROJ: begin
					h_q <= h_nx;
					d_q <= d_q + DimW'(1);
					if (d_q == DimW'(Dim - 1)) begin
						d_q <= '0;
						jobs_q <= jobs_q - 2'd1;
						hstep_q <= '0;
						hb_q <= (hn_q == 2'd3) ? {hb_q[15:0], job_c_q} : {16'h0, job_c_q};
					end
					if (d_q == '0 && jobs_q == 2'd2 && hn_q == 2'd3) begin
						hb_q <= hb_q;
					end
				end
				ST_MAX: begin
					if (mag > m_q) m_q <= mag;
					d_q <= d_q + DimW'(1);
					if (d_q == DimW'(Dim - 1)) begin
						d_q <= '0;
						k_q <= '0;
						s_q <= '0;
					end
				end
				ST_SHIFT: if (m_q >= 32'h04000000) begin
					m_q <= m_q >> 1;
					k_q <= k_q + 5'd1;
				end
				ST_SUMSQ: begin
					sx_q <= sx_q + 64'(vsq);
					d_q <= d_q + DimW'(1);
					if (d_q == DimW'(Dim - 1)) begin
						d_q <= '0;
						sqi_q <= '0;
						r_q <= '0;
						s_q <= '0;
					end
				end
				ST_SQRT: begin
					sx_q <= sx_q << 2;
					sqi_q <= sqi_q + 6'd1;
					if (!sq_try[33]) begin
						s_q <= {30'h0, sq_try};
						r_q <= {r_q[30:0], 1'b1};
					end else begin
						s_q <= {30'h0, sq_rem_sh};
						r_q <= {r_q[30:0], 1'b0};
					end
					if (sqi_q == 6'd31) dvi_q <= '0;
				end
				ST_DIV: begin
					if (dvi_q == '0) begin
						num_q <= {7'h0, v, 15'h0} + 48'(r_q >> 1);
						rem_q <= '0;
						neg_q <= head[31];
						dvi_q <= 6'd1;
					end else if (dvi_q != 6'd49) begin
						if ({rem_q[31:0], num_q[47]} >= {1'b0, r_q}) begin
							rem_q <= {rem_q[31:0], num_q[47]} - {1'b0, r_q};
							num_q <= {num_q[46:0], 1'b1};
						end else begin
							rem_q <= {rem_q[31:0], num_q[47]};
							num_q <= {num_q[46:0], 1'b0};
						end
						dvi_q <= dvi_q + 6'd1;
					end else begin
						if (r_q == '0) val_q <= '0;
						else if (neg_q) val_q <= (num_q > 48'd32768) ? 16'h8000 :
						                         16'(17'h10000 - 17'(num_q));
						else val_q <= (num_q > 48'd32767) ? 16'h7FFF : 16'(num_q);
						ov_q <= 1'b1;
					end
				end
				ST_EMIT: if (out_ready) begin
					ov_q <= 1'b0;
					dvi_q <= '0;
					d_q <= d_q + DimW'(1);
					if (d_q == DimW'(Dim - 1)) begin
						d_q <= '0;
						win_q <= '0;
						cnt_q <= '0;
						pend_q <= 1'b0;
						eot_q <= 1'b0;
						m_q <= '0;
						sx_q <= '0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_IDLE && in_valid) sx_q <= sx_q;
		end
	end

	thte_row u_row (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .proj(h_q[63:48]), .head(head)
	);
endmodule

// ===== rtl/thte_checker.sv =====
// Port-level checker for the trigram hash text embedding block, with its bind.
// Depends on trigram_hash_text_embedding_top.
module thte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  element_index,
	input logic        last_element
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(element_index))
		else $error("result dropped");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_element |=> !in_ready)
		else $error("vector ended early");
endmodule

bind trigram_hash_text_embedding_top thte_checker u_thte_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.element_index(element_index), .last_element(last_element)
);
